[design/ddd_pkg.sv]
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, constants and the control program of the date difference sequencer.
// ----------------------------------------------------------------------------
package ddd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned ORD_W   = 23;
	localparam int unsigned STEP_W  = 4;
	localparam int unsigned QUART_W = YEAR_W - 2;
	localparam int unsigned CENT_W  = 8;
	localparam int unsigned PROD_W  = 25;
	localparam int unsigned RECIP_SHIFT = 17;

	localparam logic [12:0]        RECIP_25   = 13'd5243;
	localparam logic [ORD_W-1:0]   COUNT_MAX  = ORD_W'(4194303);
	localparam logic [STEP_W-1:0]  PROG_LEN   = STEP_W'(12);

	localparam logic [2:0] REG_COUNT_END_DAY = 3'd0;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef enum logic [2:0] {
		OP_DIVY,
		OP_LEAP,
		OP_DIVP,
		OP_BASE,
		OP_CENT,
		OP_SAVE,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               sel_end;
		logic               jmp_bad;
		logic [STEP_W-1:0]  target;
	} ctrl_t;

	function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{op: OP_DONE, sel_end: 1'b0, jmp_bad: 1'b0, target: '0};
		case (step)
			4'd0:  w = '{op: OP_DIVY, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
			4'd1:  w = '{op: OP_LEAP, sel_end: 1'b0, jmp_bad: 1'b1, target: 4'd11};
			4'd2:  w = '{op: OP_DIVP, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
			4'd3:  w = '{op: OP_BASE, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
			4'd4:  w = '{op: OP_CENT, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
			4'd5:  w = '{op: OP_SAVE, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
			4'd6:  w = '{op: OP_DIVY, sel_end: 1'b1, jmp_bad: 1'b0, target: 4'd0};
			4'd7:  w = '{op: OP_LEAP, sel_end: 1'b1, jmp_bad: 1'b1, target: 4'd11};
			4'd8:  w = '{op: OP_DIVP, sel_end: 1'b1, jmp_bad: 1'b0, target: 4'd0};
			4'd9:  w = '{op: OP_BASE, sel_end: 1'b1, jmp_bad: 1'b0, target: 4'd0};
			4'd10: w = '{op: OP_CENT, sel_end: 1'b1, jmp_bad: 1'b0, target: 4'd0};
			default: w = '{op: OP_DONE, sel_end: 1'b0, jmp_bad: 1'b0, target: 4'd0};
		endcase
		return w;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m) inside
			4'd2:                        r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:     r = 5'd30;
			default:                     r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

[design/date_difference_in_days.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days
// Gregorian day count between a start date and an end date.
// ----------------------------------------------------------------------------
// Each input beat carries two dates; its result beat is set by a 12-step
// control program that skips to its end once a date is found invalid and
// reuses one 12x13 bit reciprocal multiplier for the year divisions by
// 100 of both dates; a shift of that quotient gives the division by 400.
// A new beat is taken once the program ends, also while the previous
// result still waits. invalid_date flags a bad month or day in either
// date, with day_count forced to zero. day_count is zero when the start
// is not before the end, plus one when count_end_day is set, saturated
// at the 22-bit maximum.
module date_difference_in_days (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [13:0] start_year,
	input  logic [4:0]  end_day,
	input  logic [3:0]  end_month,
	input  logic [13:0] end_year,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [21:0] day_count,
	output logic        invalid_date,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ddd_pkg::state_t                  state_q;
	logic [ddd_pkg::STEP_W-1:0]       step_q;
	logic                             ced_q;
	logic                             out_valid_q;
	logic [ddd_pkg::COUNT_W-1:0]      count_q;
	logic                             bad_out_q;

	logic [ddd_pkg::DAY_W-1:0]        sd_q, ed_q;
	logic [ddd_pkg::MONTH_W-1:0]      sm_q, em_q;
	logic [ddd_pkg::YEAR_W-1:0]       sy_q, ey_q;

	logic [ddd_pkg::PROD_W-1:0]       mul_q;
	logic [ddd_pkg::ORD_W-1:0]        acc_q;
	logic [ddd_pkg::ORD_W-1:0]        ord_a_q;
	logic                             leap_q;
	logic                             bad_q;

	ddd_pkg::ctrl_t                   ctrl;
	logic                             in_acc;
	logic                             out_acc;
	logic                             cfg_wr;

	logic [ddd_pkg::DAY_W-1:0]        d_sel;
	logic [ddd_pkg::MONTH_W-1:0]      m_sel;
	logic [ddd_pkg::YEAR_W-1:0]       y_sel;
	logic [ddd_pkg::YEAR_W-1:0]       p_sel;
	logic [ddd_pkg::QUART_W-1:0]      mul_in;
	logic [ddd_pkg::CENT_W-1:0]       q;
	logic                             cent0;
	logic                             leap_now;
	logic                             date_ok;
	logic [ddd_pkg::ORD_W-1:0]        base;
	logic [ddd_pkg::ORD_W-1:0]        cent_add;
	logic [ddd_pkg::ORD_W-1:0]        diff;
	logic [ddd_pkg::ORD_W-1:0]        cnt_sat;
	logic [ddd_pkg::ORD_W-1:0]        cnt_inc;
	logic [ddd_pkg::ORD_W-1:0]        cnt_fin;
	logic                             done_go;

	assign ctrl    = ddd_pkg::rom_word(step_q);
	assign in_stall = (state_q == ddd_pkg::ST_RUN);
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign out_valid    = out_valid_q;
	assign day_count    = count_q;
	assign invalid_date = bad_out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ddd_pkg::REG_COUNT_END_DAY);
	assign prdata = (paddr == ddd_pkg::REG_COUNT_END_DAY) ? {31'd0, ced_q} : 32'd0;

	// operand selection
	assign d_sel  = ctrl.sel_end ? ed_q : sd_q;
	assign m_sel  = ctrl.sel_end ? em_q : sm_q;
	assign y_sel  = ctrl.sel_end ? ey_q : sy_q;
	assign p_sel  = y_sel - ddd_pkg::YEAR_W'(1);
	assign mul_in = (ctrl.op == ddd_pkg::OP_DIVP) ? p_sel[ddd_pkg::YEAR_W-1:2]
		: y_sel[ddd_pkg::YEAR_W-1:2];
	assign q      = mul_q[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];

	// leap test from (y/4)/25
	assign cent0    = (y_sel[1:0] == 2'd0)
		&& (y_sel[ddd_pkg::YEAR_W-1:2] == (ddd_pkg::QUART_W'(q) * ddd_pkg::QUART_W'(25)));
	assign leap_now = (y_sel[1:0] == 2'd0) && (!cent0 || (q[1:0] == 2'd0));
	assign date_ok  = (m_sel >= 4'd1) && (m_sel <= 4'd12) && (d_sel != '0)
		&& (d_sel <= ddd_pkg::month_len(m_sel, leap_now));

	assign base = ddd_pkg::ORD_W'(y_sel) * ddd_pkg::ORD_W'(365)
		+ ddd_pkg::ORD_W'(ddd_pkg::days_before(m_sel))
		+ ddd_pkg::ORD_W'((m_sel > 4'd2) && leap_q)
		+ ddd_pkg::ORD_W'(d_sel) - ddd_pkg::ORD_W'(1);

	assign cent_add = (y_sel == '0) ? '0
		: ddd_pkg::ORD_W'(p_sel[ddd_pkg::YEAR_W-1:2]) - ddd_pkg::ORD_W'(q)
		+ ddd_pkg::ORD_W'(q[ddd_pkg::CENT_W-1:2]) + ddd_pkg::ORD_W'(1);

	assign diff    = (acc_q > ord_a_q) ? (acc_q - ord_a_q) : '0;
	assign cnt_sat = (diff > ddd_pkg::COUNT_MAX) ? ddd_pkg::COUNT_MAX : diff;
	assign cnt_inc = cnt_sat + ddd_pkg::ORD_W'(ced_q);
	assign cnt_fin = (cnt_inc > ddd_pkg::COUNT_MAX) ? ddd_pkg::COUNT_MAX : cnt_inc;

	assign done_go = (state_q == ddd_pkg::ST_RUN) && (ctrl.op == ddd_pkg::OP_DONE)
		&& (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ced_q <= 1'b0;
		end else if (cfg_wr) begin
			ced_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddd_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc && !done_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ddd_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= ddd_pkg::ST_RUN;
						step_q  <= '0;
					end
				end
				ddd_pkg::ST_RUN: begin
					if (ctrl.op == ddd_pkg::OP_DONE) begin
						if (done_go) begin
							state_q     <= ddd_pkg::ST_IDLE;
							out_valid_q <= 1'b1;
						end
					end else if (ctrl.jmp_bad && (bad_q || !date_ok)) begin
						step_q <= ctrl.target;
					end else begin
						step_q <= step_q + ddd_pkg::STEP_W'(1);
					end
				end
				default: begin
					state_q <= ddd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sd_q  <= start_day;
			sm_q  <= start_month;
			sy_q  <= start_year;
			ed_q  <= end_day;
			em_q  <= end_month;
			ey_q  <= end_year;
			bad_q <= 1'b0;
		end else if (state_q == ddd_pkg::ST_RUN) begin
			case (ctrl.op) inside
				ddd_pkg::OP_DIVY, ddd_pkg::OP_DIVP: begin
					mul_q <= ddd_pkg::PROD_W'(mul_in) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_25);
				end
				ddd_pkg::OP_LEAP: begin
					leap_q <= leap_now;
					bad_q  <= bad_q || !date_ok;
				end
				ddd_pkg::OP_BASE: begin
					acc_q <= base;
				end
				ddd_pkg::OP_CENT: begin
					acc_q <= acc_q + cent_add;
				end
				ddd_pkg::OP_SAVE: begin
					ord_a_q <= acc_q;
				end
				default: begin
				end
			endcase
		end
		if (done_go) begin
			count_q   <= bad_q ? '0 : cnt_fin[ddd_pkg::COUNT_W-1:0];
			bad_out_q <= bad_q;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_date |-> day_count == '0)
		else $error("invalid result with nonzero count");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ddd_pkg::ST_RUN && step_q == '0)
		else $error("program did not start at step zero");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ddd_pkg::ST_RUN |-> step_q < ddd_pkg::PROG_LEN)
		else $error("step counter beyond program");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ddd_pkg::ST_RUN))
		else $error("result without a running program");

endmodule

[bench/date_difference_in_days_test.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days_test
// Self-checking bench for the Gregorian day count between two dates.
// ----------------------------------------------------------------------------
// A queue of date pairs feeds a clocked driver on the input channel; a clocked
// monitor on the result channel checks each beat against a local calculation
// of the day ordinals. Directed pairs cover the field extremes, leap rules,
// bad dates, reversed pairs and saturation. Random pairs are mostly real
// calendar dates with some corrupted and raw noise. Both sides idle at
// random; the end-day register is toggled between phases over the APB port.
module date_difference_in_days_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RESET_CYCLES  = 12;
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned WATCHDOG_MAX  = 4000;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned IDLE_PCT      = 37;
	localparam int unsigned COUNT_TOP     = (1 << ddd_pkg::COUNT_W) - 1;
	localparam logic [2:0]  ADDR_UNUSED   = 3'd4;

	typedef struct packed {
		logic [ddd_pkg::DAY_W-1:0]   day;
		logic [ddd_pkg::MONTH_W-1:0] month;
		logic [ddd_pkg::YEAR_W-1:0]  year;
	} cal_date_t;

	typedef struct packed {
		cal_date_t origin;
		cal_date_t target;
	} date_pair_t;

	typedef struct packed {
		date_pair_t                  dates;
		logic [ddd_pkg::COUNT_W-1:0] days;
		logic                        bad;
	} day_span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  start_day = '0;
	logic [3:0]  start_month = '0;
	logic [13:0] start_year = '0;
	logic [4:0]  end_day = '0;
	logic [3:0]  end_month = '0;
	logic [13:0] end_year = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [21:0] day_count;
	logic        invalid_date;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	date_pair_t  date_pairs[$];
	day_span_t   awaited_spans[$];
	bit          end_day_on = 1'b0;
	int unsigned sender_idle = IDLE_PCT;
	int unsigned receiver_idle = IDLE_PCT;
	bit          hold_burst_req = 1'b0;
	int unsigned dates_queued = 0;
	int unsigned results_checked = 0;
	int unsigned errors = 0;
	int unsigned invalid_seen = 0;
	int unsigned saturated_seen = 0;
	int unsigned idle_cycles = 0;

	date_difference_in_days dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_day(start_day), .start_month(start_month), .start_year(start_year),
		.end_day(end_day), .end_month(end_month), .end_year(end_year),
		.out_valid(out_valid), .out_stall(out_stall),
		.day_count(day_count), .invalid_date(invalid_date),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// calendar arithmetic

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m) inside
			2:          return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	function automatic bit real_date(input cal_date_t d);
		return d.month >= 1 && d.month <= 12 && d.day >= 1 &&
			d.day <= month_days(d.month, d.year);
	endfunction

	// days since 0000-01-01, year 0 counted as leap
	function automatic int unsigned day_number(input cal_date_t d);
		int unsigned n;
		int unsigned p;
		n = 365 * d.year;
		if (d.year > 0) begin
			p = d.year - 1;
			n += p / 4 - p / 100 + p / 400 + 1;
		end
		for (int unsigned m = 1; m < d.month; m++)
			n += month_days(m, d.year);
		return n + d.day - 1;
	endfunction

	function automatic day_span_t days_between(input date_pair_t p, input bit with_end);
		day_span_t   s;
		int unsigned a;
		int unsigned b;
		int unsigned n;
		s.dates = p;
		s.days = '0;
		s.bad = 1'b0;
		n = 0;
		if (!real_date(p.origin) || !real_date(p.target)) begin
			s.bad = 1'b1;
		end else begin
			a = day_number(p.origin);
			b = day_number(p.target);
			if (a < b)
				n = b - a;
			n += with_end;
			if (n > COUNT_TOP)
				n = COUNT_TOP;
			s.days = n[ddd_pkg::COUNT_W-1:0];
		end
		return s;
	endfunction

	// random stimulus

	function automatic int unsigned rand_year();
		int t;
		case ($urandom_range(9)) inside
			0, 1, 2, 3: return $urandom_range(16383);
			4, 5, 6:    return $urandom_range(9999);
			7: begin
				t = int'($urandom_range(163)) * 100 + int'($urandom_range(2)) - 1;
				if (t < 0)
					t = 0;
				if (t > 16383)
					t = 16383;
				return t;
			end
			8:          return $urandom_range(3);
			default:    return $urandom_range(16383, 16380);
		endcase
	endfunction

	function automatic cal_date_t rand_date(input int unsigned y);
		cal_date_t   d;
		int unsigned len;
		d.year = ddd_pkg::YEAR_W'(y);
		d.month = ddd_pkg::MONTH_W'($urandom_range(12, 1));
		len = month_days(d.month, y);
		d.day = ddd_pkg::DAY_W'(($urandom_range(4) == 0) ? len : $urandom_range(len, 1));
		return d;
	endfunction

	function automatic date_pair_t rand_pair();
		date_pair_t  p;
		cal_date_t   d;
		logic [63:0] raw;
		int unsigned r;
		int unsigned y;
		int unsigned len;
		r = $urandom_range(99);
		if (r < 15) begin
			raw = {$urandom, $urandom};
			p = raw[$bits(date_pair_t)-1:0];
		end else begin
			p.origin = rand_date(rand_year());
			if ($urandom_range(9) < 4) begin
				y = p.origin.year;
				if ($urandom_range(1) && y < 16383)
					y++;
				else if ($urandom_range(1) && y > 0)
					y--;
				p.target = rand_date(y);
			end else begin
				p.target = rand_date(rand_year());
			end
			if ($urandom_range(1)) begin
				d = p.origin;
				p.origin = p.target;
				p.target = d;
			end
			if (r < 22) begin
				d = $urandom_range(1) ? p.origin : p.target;
				len = month_days(d.month, d.year);
				case ($urandom_range(2))
					0: d.day = '0;
					1: d.month = ddd_pkg::MONTH_W'(($urandom_range(3) == 0) ? 0
						: $urandom_range(15, 13));
					default: begin
						if (len < 31)
							d.day = ddd_pkg::DAY_W'($urandom_range(31, len + 1));
						else
							d.month = ddd_pkg::MONTH_W'(13);
					end
				endcase
				if ($urandom_range(1))
					p.origin = d;
				else
					p.target = d;
			end
		end
		return p;
	endfunction

	task automatic queue_dates(input int unsigned sd, input int unsigned sm,
			input int unsigned sy, input int unsigned ed, input int unsigned em,
			input int unsigned ey);
		date_pair_t p;
		p.origin = '{day: ddd_pkg::DAY_W'(sd), month: ddd_pkg::MONTH_W'(sm),
			year: ddd_pkg::YEAR_W'(sy)};
		p.target = '{day: ddd_pkg::DAY_W'(ed), month: ddd_pkg::MONTH_W'(em),
			year: ddd_pkg::YEAR_W'(ey)};
		date_pairs.push_back(p);
		dates_queued++;
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n) begin
			date_pairs.push_back(rand_pair());
			dates_queued++;
		end
	endtask

	task automatic drain();
		while (results_checked != dates_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] data, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_end_day(input bit v);
		logic [31:0] rd;
		drain();
		reg_access(1'b1, ddd_pkg::REG_COUNT_END_DAY, {31'b0, v}, rd);
		end_day_on = v;
		reg_access(1'b0, ddd_pkg::REG_COUNT_END_DAY, '0, rd);
		if (rd !== {31'b0, v}) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("register read back %0h, expected %0h", rd, v);
		end
	endtask

	// input driver
	always @(posedge clk) begin : feed
		bit         took;
		bit         load;
		date_pair_t on_bus;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (took)
				awaited_spans.push_back(days_between(on_bus, end_day_on));
			load = (!in_valid || took) && date_pairs.size() != 0 &&
				$urandom_range(99) >= sender_idle;
			if (load) begin
				on_bus = date_pairs.pop_front();
				start_day <= on_bus.origin.day;
				start_month <= on_bus.origin.month;
				start_year <= on_bus.origin.year;
				end_day <= on_bus.target.day;
				end_month <= on_bus.target.month;
				end_year <= on_bus.target.year;
				in_valid <= 1'b1;
			end else if (took) begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : observe
		day_span_t   want;
		int unsigned hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (awaited_spans.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("unexpected result beat: count %0d invalid %0b",
							day_count, invalid_date);
				end else begin
					want = awaited_spans.pop_front();
					invalid_seen += want.bad;
					saturated_seen += (want.days == COUNT_TOP);
					if (day_count !== want.days || invalid_date !== want.bad) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("mismatch %0d-%0d-%0d to %0d-%0d-%0d:",
								want.dates.origin.year, want.dates.origin.month,
								want.dates.origin.day, want.dates.target.year,
								want.dates.target.month, want.dates.target.day);
							$display("  expected count %0d invalid %0b, got %0d %0b",
								want.days, want.bad, day_count, invalid_date);
						end
					end
				end
			end
			if (hold_burst_req) begin
				hold_burst_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("no handshake for %0d cycles, %0d of %0d results seen",
				idle_cycles, results_checked, dates_queued);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] rd;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write to a hole in the map must leave the end-day setting alone
		reg_access(1'b1, ADDR_UNUSED, 32'd1, rd);

		queue_dates(1, 1, 0, 1, 1, 0);
		queue_dates(1, 1, 0, 2, 1, 0);
		queue_dates(1, 1, 0, 31, 12, 9999);
		queue_dates(1, 1, 0, 31, 12, 16383);
		queue_dates(31, 12, 16383, 1, 1, 0);
		queue_dates(28, 2, 2000, 1, 3, 2000);
		queue_dates(28, 2, 1900, 1, 3, 1900);
		queue_dates(29, 2, 1900, 1, 3, 1900);
		queue_dates(29, 2, 2004, 1, 1, 2005);
		queue_dates(29, 2, 2100, 1, 1, 2200);
		queue_dates(29, 2, 0, 1, 3, 0);
		queue_dates(31, 12, 1999, 1, 1, 2000);
		queue_dates(1, 0, 2000, 1, 1, 2001);
		queue_dates(1, 1, 2000, 1, 13, 2001);
		queue_dates(1, 15, 2000, 1, 1, 2001);
		queue_dates(0, 1, 2000, 1, 1, 2001);
		queue_dates(31, 4, 2000, 1, 5, 2000);
		queue_dates(31, 1, 16383, 31, 12, 16383);
		queue_dates(1, 1, 2000, 30, 2, 2000);
		queue_dates(1, 1, 9999, 31, 12, 9999);
		queue_dates(17, 6, 5000, 17, 6, 5000);
		queue_random(450);

		set_end_day(1'b1);
		queue_dates(17, 6, 5000, 17, 6, 5000);
		queue_dates(1, 1, 0, 31, 12, 16383);
		queue_dates(30, 2, 2001, 1, 1, 2002);
		queue_random(200);
		drain();
		queue_random(250);

		// receiver holds off while the sender keeps offering
		set_end_day(1'b0);
		queue_random(150);
		hold_burst_req = 1'b1;
		queue_random(300);

		set_end_day(1'b1);
		sender_idle = 0;
		receiver_idle = 0;
		queue_random(200);
		drain();
		sender_idle = IDLE_PCT;
		receiver_idle = IDLE_PCT;
		queue_random(250);
		drain();

		if (awaited_spans.size() != 0) begin
			errors += awaited_spans.size();
			$display("%0d expected results never arrived", awaited_spans.size());
		end
		$display("checked %0d date pairs with end-day counting off and on",
			results_checked);
		$display("%0d had an invalid date, %0d hit the count ceiling, %0d errors",
			invalid_seen, saturated_seen, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
